// ----- src/kmp_pkg.sv -----
// Shared types and constants for the streaming KMP matcher.
// Used by kmp_engine, kmp_out_stage and kmp_stream_matcher; depends on nothing.
package kmp_pkg;

  localparam int KMP_MAX_PATTERN   = 256;
  localparam int KMP_SYMBOL_BITS   = 8;
  localparam int KMP_POSITION_BITS = 32;
  localparam int KMP_START_W       = 32;

  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_APPEND = 2'd1,
    OP_TEXT   = 2'd2,
    OP_NOP    = 2'd3
  } kmp_op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_NOPAT = 2'd2
  } kmp_status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_WALK,
    S_FINISH
  } kmp_state_t;

  typedef struct packed {
    logic                   found;
    logic [KMP_START_W-1:0] match_start;
    kmp_status_t            status;
  } kmp_res_t;

endpackage

// ----- src/kmp_ram.sv -----
// Generic single-port-write, single-port-read RAM with a registered read.
// Stands alone; instanced for the pattern store and the failure table.
module kmp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ----- src/kmp_engine.sv -----
// Request sequencer of the KMP matcher: pattern store and failure table in RAM,
// failure-link walks one step a cycle. Depends on kmp_pkg and kmp_ram.
module kmp_engine #(
  parameter int MAX_PATTERN   = kmp_pkg::KMP_MAX_PATTERN,
  parameter int SYMBOL_BITS   = kmp_pkg::KMP_SYMBOL_BITS,
  parameter int POSITION_BITS = kmp_pkg::KMP_POSITION_BITS
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic [1:0]        in_opcode,
  input  logic [7:0]        in_symbol,
  output logic              in_stall,
  output logic              res_valid,
  output kmp_pkg::kmp_res_t res,
  input  logic              res_ready
);
  import kmp_pkg::*;

  localparam int IDX_W     = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
  localparam int CNT_W     = $clog2(MAX_PATTERN + 1);
  localparam int SYM_EXT_W = (SYMBOL_BITS > 8) ? SYMBOL_BITS : 8;
  localparam int DIFF_W    = (POSITION_BITS > CNT_W) ? POSITION_BITS : CNT_W;

  kmp_state_t               state_r, state_nxt;
  kmp_op_t                  op_r, op_nxt;
  logic [SYMBOL_BITS-1:0]   sym_r, sym_nxt;
  logic [IDX_W-1:0]         j_r, j_nxt;
  logic [CNT_W-1:0]         len_r, len_nxt;
  logic [IDX_W-1:0]         match_r, match_nxt;
  logic [IDX_W-1:0]         lastf_r, lastf_nxt;
  logic [POSITION_BITS-1:0] pos_r, pos_nxt;
  kmp_res_t                 res_r, res_nxt;

  logic                     accept;
  kmp_op_t                  in_op;
  logic [SYM_EXT_W-1:0]     sym_ext;
  logic [SYMBOL_BITS-1:0]   in_sym;
  logic                     len_lt_max;

  logic                     pat_we, fail_we;
  logic [IDX_W-1:0]         pat_waddr, fail_waddr;
  logic [SYMBOL_BITS-1:0]   pat_wdata, pat_rdata;
  logic [IDX_W-1:0]         fail_wdata, fail_rdata;
  logic [IDX_W-1:0]         rd_base;

  logic                     sym_eq, walk_end, found_now;
  logic [CNT_W-1:0]         j_ext;
  logic [DIFF_W-1:0]        start_w;

  assign accept     = in_valid && (state_r == S_IDLE);
  assign in_op      = kmp_op_t'(in_opcode);
  assign sym_ext    = SYM_EXT_W'(in_symbol);
  assign in_sym     = sym_ext[SYMBOL_BITS-1:0];
  assign len_lt_max = len_r < CNT_W'(MAX_PATTERN);

  assign sym_eq    = (pat_rdata == sym_r);
  assign walk_end  = sym_eq || (j_r == '0);
  assign j_ext     = CNT_W'(j_r) + CNT_W'(sym_eq);
  assign found_now = (j_ext == len_r);
  assign start_w   = DIFF_W'(pos_r) + DIFF_W'(1) - DIFF_W'(len_r);

  // Both memories are read at the candidate count each cycle: the symbol at j
  // and the failure entry for j-1, which is the next count on a mismatch.
  kmp_ram #(.WIDTH(SYMBOL_BITS), .DEPTH(MAX_PATTERN), .AW(IDX_W)) u_pat_ram (
    .clk   (clk),
    .we    (pat_we),
    .waddr (pat_waddr),
    .wdata (pat_wdata),
    .raddr (rd_base),
    .rdata (pat_rdata)
  );

  kmp_ram #(.WIDTH(IDX_W), .DEPTH(MAX_PATTERN), .AW(IDX_W)) u_fail_ram (
    .clk   (clk),
    .we    (fail_we),
    .waddr (fail_waddr),
    .wdata (fail_wdata),
    .raddr (rd_base - IDX_W'(1)),
    .rdata (fail_rdata)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          if ((in_op == OP_APPEND && len_r != '0 && len_lt_max) ||
              (in_op == OP_TEXT && len_r != '0)) begin
            state_nxt = S_WALK;
          end else begin
            state_nxt = S_FINISH;
          end
        end
      end
      S_WALK: begin
        if (walk_end) begin
          state_nxt = S_FINISH;
        end
      end
      S_FINISH: begin
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    op_nxt     = op_r;
    sym_nxt    = sym_r;
    j_nxt      = j_r;
    len_nxt    = len_r;
    match_nxt  = match_r;
    lastf_nxt  = lastf_r;
    pos_nxt    = pos_r;
    res_nxt    = res_r;
    pat_we     = 1'b0;
    fail_we    = 1'b0;
    pat_waddr  = len_r[IDX_W-1:0];
    pat_wdata  = in_sym;
    fail_waddr = len_r[IDX_W-1:0];
    fail_wdata = '0;
    rd_base    = fail_rdata;
    in_stall   = 1'b1;
    unique case (state_r)
      S_IDLE: begin
        in_stall = 1'b0;
        rd_base  = (in_op == OP_TEXT) ? match_r : lastf_r;
        if (accept) begin
          op_nxt  = in_op;
          sym_nxt = in_sym;
          j_nxt   = rd_base;
          res_nxt = '{found: 1'b0, match_start: '0, status: ST_OK};
          unique case (in_op)
            OP_CLEAR: begin
              len_nxt   = '0;
              match_nxt = '0;
              pos_nxt   = '0;
            end
            OP_APPEND: begin
              if (!len_lt_max) begin
                res_nxt.status = ST_FULL;
              end else begin
                pat_we = 1'b1;
                // The first symbol has an empty proper border, so no walk.
                if (len_r == '0) begin
                  fail_we   = 1'b1;
                  len_nxt   = CNT_W'(1);
                  lastf_nxt = '0;
                end
              end
            end
            OP_TEXT: begin
              if (len_r == '0) begin
                res_nxt.status = ST_NOPAT;
                pos_nxt        = pos_r + POSITION_BITS'(1);
              end
            end
            default: ;
          endcase
        end
      end
      S_WALK: begin
        j_nxt = fail_rdata;
        if (walk_end) begin
          if (op_r == OP_APPEND) begin
            fail_we    = 1'b1;
            fail_wdata = j_ext[IDX_W-1:0];
            lastf_nxt  = j_ext[IDX_W-1:0];
            len_nxt    = len_r + CNT_W'(1);
          end else begin
            pos_nxt = pos_r + POSITION_BITS'(1);
            if (found_now) begin
              res_nxt.found       = 1'b1;
              res_nxt.match_start = KMP_START_W'(start_w[POSITION_BITS-1:0]);
              match_nxt           = lastf_r;
            end else begin
              match_nxt = j_ext[IDX_W-1:0];
            end
          end
        end
      end
      S_FINISH: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      len_r   <= '0;
      match_r <= '0;
      lastf_r <= '0;
      pos_r   <= '0;
    end else begin
      state_r <= state_nxt;
      len_r   <= len_nxt;
      match_r <= match_nxt;
      lastf_r <= lastf_nxt;
      pos_r   <= pos_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r  <= op_nxt;
    sym_r <= sym_nxt;
    j_r   <= j_nxt;
    res_r <= res_nxt;
  end

  assign res_valid = (state_r == S_FINISH);
  assign res       = res_r;

  a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    len_r <= CNT_W'(MAX_PATTERN))
    else $error("pattern length exceeds capacity");

  a_match_below_len: assert property (@(posedge clk) disable iff (!rst_n)
    (len_r != '0) || (match_r == '0))
    else $error("matched count nonzero with empty pattern");

  a_match_lt_len: assert property (@(posedge clk) disable iff (!rst_n)
    (len_r != '0) |-> (CNT_W'(match_r) < len_r))
    else $error("matched count not below pattern length");

  a_walk_index: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WALK) |-> (CNT_W'(j_r) < len_r))
    else $error("failure walk index outside the pattern");

  a_finish_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FINISH && !res_ready) |=> (state_r == S_FINISH && $stable(res_r)))
    else $error("pending result lost before the output stage took it");

endmodule

// ----- src/kmp_out_stage.sv -----
// Output register of the KMP matcher: holds one result until the receiver takes it.
// Depends on kmp_pkg for the result type.
module kmp_out_stage (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             res_valid,
  input  kmp_pkg::kmp_res_t                res,
  output logic                             res_ready,
  output logic                             out_valid,
  output logic                             out_found,
  output logic [kmp_pkg::KMP_START_W-1:0]  out_match_start,
  output logic [1:0]                       out_status,
  input  logic                             out_stall
);
  import kmp_pkg::*;

  logic     valid_r, valid_nxt;
  kmp_res_t data_r, data_nxt;
  logic     take;

  assign res_ready = !valid_r || !out_stall;
  assign take      = res_valid && res_ready;

  always_comb begin
    data_nxt = data_r;
    if (take) begin
      valid_nxt = 1'b1;
      data_nxt  = res;
    end else if (!out_stall) begin
      valid_nxt = 1'b0;
    end else begin
      valid_nxt = valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign out_valid       = valid_r;
  assign out_found       = data_r.found;
  assign out_match_start = data_r.match_start;
  assign out_status      = data_r.status;

endmodule

// ----- src/kmp_stream_matcher.sv -----
// Streaming Knuth-Morris-Pratt matcher, top level.
// Depends on kmp_pkg, kmp_engine (with kmp_ram) and kmp_out_stage.
//
// Input channel: in_opcode selects clear, append pattern symbol, text symbol or
// no operation; in_symbol carries the symbol. A request is taken when in_valid
// is high and in_stall is low. Every request gives exactly one result on the
// output channel (out_found, out_match_start, out_status), taken when out_valid
// is high and out_stall is low.
// Sequence: clear, no operation, a dropped append, the first append and text with
// no pattern go from acceptance straight to the finish state and then to the
// output register; an append or text request with a pattern loaded first passes
// through the walk state, which follows failure links until the symbol matches
// or the count is zero. The walk reads the pattern RAM and the failure RAM once
// per cycle each. Failure steps never outnumber advances. The next request is
// taken only once the engine is back in idle, after its result has left the
// finish state. One request is in work at a time.
// Reset (synchronous, rst_n low) empties the pattern, zeroes the matched count
// and text position and drops any held result; the RAMs are not cleared.
// While the receiver stalls, the result register holds; one further finished
// result waits inside the engine and the input stalls until it can move on.
module kmp_stream_matcher #(
  parameter int MAX_PATTERN   = kmp_pkg::KMP_MAX_PATTERN,
  parameter int SYMBOL_BITS   = kmp_pkg::KMP_SYMBOL_BITS,
  parameter int POSITION_BITS = kmp_pkg::KMP_POSITION_BITS
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  input  logic [1:0]                      in_opcode,
  input  logic [7:0]                      in_symbol,
  output logic                            in_stall,
  output logic                            out_valid,
  output logic                            out_found,
  output logic [kmp_pkg::KMP_START_W-1:0] out_match_start,
  output logic [1:0]                      out_status,
  input  logic                            out_stall
);
  import kmp_pkg::*;

  logic     res_valid;
  logic     res_ready;
  kmp_res_t res;

  kmp_engine #(
    .MAX_PATTERN   (MAX_PATTERN),
    .SYMBOL_BITS   (SYMBOL_BITS),
    .POSITION_BITS (POSITION_BITS)
  ) u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_opcode (in_opcode),
    .in_symbol (in_symbol),
    .in_stall  (in_stall),
    .res_valid (res_valid),
    .res       (res),
    .res_ready (res_ready)
  );

  kmp_out_stage u_out (
    .clk             (clk),
    .rst_n           (rst_n),
    .res_valid       (res_valid),
    .res             (res),
    .res_ready       (res_ready),
    .out_valid       (out_valid),
    .out_found       (out_found),
    .out_match_start (out_match_start),
    .out_status      (out_status),
    .out_stall       (out_stall)
  );

endmodule
